### hdl/hkrb_pkg.sv
// Package for the HID boot keyboard report builder.
// Holds item kinds, register indexes, report constants and the stage structs.
// No dependencies.
package hkrb_pkg;

    localparam int MAX_SLOTS = 6;
    localparam int CFG_ADDR_W = 8;

    typedef enum logic [1:0] {
        KIND_SCAN_START = 2'd0,
        KIND_KEY        = 2'd1,
        KIND_SCAN_END   = 2'd2,
        KIND_TICK       = 2'd3
    } t_kind;

    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_RATE     = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MODIFIER_BASE = 8'd1;

    localparam logic [7:0] IDLE_RATE_RESET     = 8'd0;
    localparam logic [7:0] MODIFIER_BASE_RESET = 8'd223;

    localparam logic [7:0] ROLLOVER_CODE = 8'h01;
    localparam logic [7:0] FIRST_MOD_BIT = 8'h01;
    localparam logic [8:0] MOD_SPAN      = 9'd9;
    localparam logic [7:0] IDLE_LIMIT    = 8'd4;
    localparam logic [7:0] IDLE_STEP     = 8'd5;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] key_code;
        logic       host_ready;
    } t_item;

    typedef struct packed {
        logic                          send;
        logic [7:0]                    modifier_bits;
        logic [MAX_SLOTS-1:0][7:0]     slots;
        logic                          rolled_over;
    } t_result;

endpackage

### hdl/hkrb_if.sv
// Valid/ready channel interfaces of the report builder: key items, reports,
// register writes. Uses hkrb_pkg for the register address width.
interface hkrb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] key_code;
    logic       host_ready;

    modport source (output valid, kind, key_code, host_ready, input ready);
    modport sink   (input valid, kind, key_code, host_ready, output ready);
endinterface

interface hkrb_out_if;
    logic       valid;
    logic       ready;
    logic       send;
    logic [7:0] modifier_bits;
    logic [7:0] slot_a;
    logic [7:0] slot_b;
    logic [7:0] slot_c;
    logic [7:0] slot_d;
    logic [7:0] slot_e;
    logic [7:0] slot_f;
    logic       rolled_over;

    modport source (output valid, send, modifier_bits, slot_a, slot_b, slot_c, slot_d,
                    slot_e, slot_f, rolled_over, input ready);
    modport sink   (input valid, send, modifier_bits, slot_a, slot_b, slot_c, slot_d,
                    slot_e, slot_f, rolled_over, output ready);
endinterface

interface hkrb_cfg_if import hkrb_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [7:0]            data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

### hdl/hkrb_engine.sv
// Report state and per-item update logic of the report builder.
// Depends on hkrb_pkg.
module hkrb_engine import hkrb_pkg::*; #(
    parameter int KEY_SLOTS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_item      i_item,
    input  logic [7:0] i_idle_rate,
    input  logic [7:0] i_modifier_base,
    output t_result    o_result
);

    localparam int SLOT_W = $clog2(KEY_SLOTS + 1);

    logic [7:0]        r_mod,  n_mod;
    logic [7:0]        r_slot [KEY_SLOTS];
    logic [7:0]        n_slot [KEY_SLOTS];
    logic [SLOT_W-1:0] r_next_slot, n_next_slot;
    logic [7:0]        r_sent_mod, n_sent_mod;
    logic [7:0]        r_sent_slot [KEY_SLOTS];
    logic [7:0]        n_sent_slot [KEY_SLOTS];
    logic [7:0]        r_idle, n_idle;
    logic              r_overflow, n_overflow;

    logic       w_is_mod;
    logic [7:0] w_mod_off;
    logic       w_changed;
    logic       w_want;
    logic       w_send;
    logic       w_all_rollover;

    assign w_is_mod  = ({1'b0, i_item.key_code} > {1'b0, i_modifier_base}) &&
                       ({1'b0, i_item.key_code} < ({1'b0, i_modifier_base} + MOD_SPAN));
    assign w_mod_off = i_item.key_code - i_modifier_base - 8'd1;

    always_comb begin
        w_changed = (r_mod != r_sent_mod);
        w_all_rollover = 1'b1;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_slot[i] != r_sent_slot[i]) begin
                w_changed = 1'b1;
            end
            if (r_slot[i] != ROLLOVER_CODE) begin
                w_all_rollover = 1'b0;
            end
        end
    end

    // Next report state for the item in the input stage.
    always_comb begin
        n_mod       = r_mod;
        n_slot      = r_slot;
        n_next_slot = r_next_slot;
        n_idle      = r_idle;
        n_overflow  = r_overflow;
        w_want      = 1'b0;
        unique case (i_item.kind)
            KIND_SCAN_START: begin
                n_mod       = '0;
                n_next_slot = '0;
                n_overflow  = 1'b0;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    n_slot[i] = '0;
                end
            end
            KIND_KEY: begin
                if (w_is_mod) begin
                    n_mod = r_mod | (FIRST_MOD_BIT << w_mod_off[2:0]);
                end else if (r_next_slot >= SLOT_W'(KEY_SLOTS)) begin
                    n_overflow = 1'b1;
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        n_slot[i] = ROLLOVER_CODE;
                    end
                end else begin
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (r_next_slot == SLOT_W'(i)) begin
                            n_slot[i] = i_item.key_code;
                        end
                    end
                    n_next_slot = r_next_slot + SLOT_W'(1);
                end
            end
            KIND_SCAN_END: begin
                w_want = (i_idle_rate == '0) ? w_changed : 1'b1;
            end
            KIND_TICK: begin
                if (i_idle_rate != '0) begin
                    if (r_idle > IDLE_LIMIT) begin
                        n_idle = r_idle - IDLE_STEP;
                    end else begin
                        w_want = 1'b1;
                        n_idle = i_idle_rate;
                    end
                end
            end
            default: begin
            end
        endcase
        w_send = w_want && i_item.host_ready;
    end

    always_comb begin
        n_sent_mod = w_send ? n_mod : r_sent_mod;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            n_sent_slot[i] = w_send ? n_slot[i] : r_sent_slot[i];
        end
    end

    always_comb begin
        o_result.send          = w_send;
        o_result.modifier_bits = n_mod;
        o_result.rolled_over   = n_overflow;
        o_result.slots         = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            o_result.slots[i] = n_slot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod       <= '0;
            r_next_slot <= '0;
            r_sent_mod  <= '0;
            r_idle      <= '0;
            r_overflow  <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_slot[i]      <= '0;
                r_sent_slot[i] <= '0;
            end
        end else if (i_fire) begin
            r_mod       <= n_mod;
            r_slot      <= n_slot;
            r_next_slot <= n_next_slot;
            r_sent_mod  <= n_sent_mod;
            r_sent_slot <= n_sent_slot;
            r_idle      <= n_idle;
            r_overflow  <= n_overflow;
        end
    end

`ifndef SYNTHESIS
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_slot <= SLOT_W'(KEY_SLOTS))
        else $error("next slot beyond key slots");

    a_send_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.send |-> i_item.host_ready)
        else $error("send without host ready");

    a_sent_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.send) |=> (r_sent_mod == r_mod && !w_changed))
        else $error("sent report differs from current report after send");

    a_overflow_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> w_all_rollover)
        else $error("overflow flag without rollover codes in slots");
`endif

endmodule

### hdl/hid_keyboard_report_builder_top.sv
// Top level of the HID boot keyboard report builder.
// Depends on hkrb_pkg, the hkrb interfaces and hkrb_engine.
//
// Builds an 8-byte boot keyboard report (modifier byte plus up to six key
// slots) from scan items and decides when it goes to the host. Every item
// yields exactly one result, which always shows the current report; send
// marks a report actually transmitted. One item is taken per clock while the
// output is not stalled: an item waits in the input register, the report
// update and the 56-bit compare against the last sent report run while it is
// there, and the result is held in the output register until taken. Each
// result passes the input register and then the output register before it
// can transfer; a stalled output holds the pipe while both registers are full.
// Register writes are taken every cycle and must only happen while no item is
// in flight.
module hid_keyboard_report_builder_top import hkrb_pkg::*; #(
    parameter int KEY_SLOTS = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hkrb_in_if.sink          i_item,
    hkrb_cfg_if.sink         i_cfg,
    hkrb_out_if.source       o_result
);

    logic       r_in_valid;
    t_item      r_in_item;
    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_idle_rate;
    logic [7:0] r_modifier_base;

    logic       w_advance;
    t_result    w_result;

    // Move the input stage forward when the output register is free or drains.
    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;
    assign i_cfg.ready  = 1'b1;

    // Register writes; addresses off the map are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_rate     <= IDLE_RATE_RESET;
            r_modifier_base <= MODIFIER_BASE_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.addr == REG_IDLE_RATE) begin
                r_idle_rate <= i_cfg.data;
            end else if (i_cfg.addr == REG_MODIFIER_BASE) begin
                r_modifier_base <= i_cfg.data;
            end
        end
    end

    // Input register: capture on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_item.kind       <= t_kind'(i_item.kind);
            r_in_item.key_code   <= i_item.key_code;
            r_in_item.host_ready <= i_item.host_ready;
        end
    end

    hkrb_engine #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_advance),
        .i_item          (r_in_item),
        .i_idle_rate     (r_idle_rate),
        .i_modifier_base (r_modifier_base),
        .o_result        (w_result)
    );

    // Output register: load on advance, drop valid once the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.send          = r_out.send;
    assign o_result.modifier_bits = r_out.modifier_bits;
    assign o_result.slot_a        = r_out.slots[0];
    assign o_result.slot_b        = r_out.slots[1];
    assign o_result.slot_c        = r_out.slots[2];
    assign o_result.slot_d        = r_out.slots[3];
    assign o_result.slot_e        = r_out.slots[4];
    assign o_result.slot_f        = r_out.slots[5];
    assign o_result.rolled_over   = r_out.rolled_over;

`ifndef SYNTHESIS
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced item did not reach the output register");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |=> (o_result.valid && $stable(r_out)))
        else $error("stalled result changed before it was taken");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_result.ready) |-> !i_item.ready)
        else $error("input taken while both registers are full and stalled");
`endif

endmodule

### dv/hid_keyboard_report_builder_top_test.sv
// Self-checking testbench for hid_keyboard_report_builder_top.
// Depends on hkrb_pkg, the hkrb channel interfaces and the block's RTL.
// A local model predicts every report; a monitor checks each one in order.
module hid_keyboard_report_builder_top_test;
    import hkrb_pkg::*;

    logic i_clk;
    logic i_rst_n;

    hkrb_in_if  item_bus ();
    hkrb_cfg_if cfg_bus ();
    hkrb_out_if report_bus ();

    hid_keyboard_report_builder_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_result (report_bus)
    );

    // Model of the report builder: register copies and report state.
    logic [7:0]                  model_idle_rate;
    logic [7:0]                  model_mod_base;
    logic [7:0]                  rep_mods;
    logic [MAX_SLOTS-1:0][7:0]   rep_slots;
    logic [2:0]                  rep_next_slot;
    logic [63:0]                 rep_last_sent;
    logic [7:0]                  rep_idle_count;
    logic                        rep_rolled;

    // Items waiting to be driven, reports waiting to be seen.
    t_item   scan_items[$];
    t_result expected_reports[$];
    t_item   last_scan[$];
    t_item   on_bus;

    int  items_queued;
    int  items_taken;
    int  reports_seen;
    int  sends_seen;
    int  errors;
    int  settings_run;
    int  src_gap;
    int  sink_gap;
    bit  no_idle;

    // Clock: 10 time units per period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #2_000_000;
        $display("timeout: %0d of %0d items taken, %0d reports outstanding",
                 items_taken, items_queued, expected_reports.size());
        $display("TEST FAILED");
        $finish;
    end

    // Advance the model by one item and return the report it should produce.
    function automatic t_result update_report(t_item it);
        t_result    res;
        logic       want;
        logic [8:0] code9;
        logic [8:0] base9;
        logic [7:0] mod_idx;
        want  = 1'b0;
        code9 = {1'b0, it.key_code};
        base9 = {1'b0, model_mod_base};
        case (it.kind)
            KIND_SCAN_START: begin
                rep_mods      = '0;
                rep_slots     = '0;
                rep_next_slot = '0;
                rep_rolled    = 1'b0;
            end
            KIND_KEY: begin
                if (code9 > base9 && code9 < base9 + MOD_SPAN) begin
                    // Modifier keys set one bit of byte 0, left ctrl first.
                    mod_idx  = it.key_code - model_mod_base - 8'd1;
                    rep_mods = rep_mods | (FIRST_MOD_BIT << mod_idx);
                end else if (rep_next_slot >= MAX_SLOTS) begin
                    // Slots full: every slot shows the rollover code.
                    for (int i = 0; i < MAX_SLOTS; i++)
                        rep_slots[i] = ROLLOVER_CODE;
                    rep_rolled = 1'b1;
                end else begin
                    rep_slots[rep_next_slot] = it.key_code;
                    rep_next_slot            = rep_next_slot + 3'd1;
                end
            end
            KIND_SCAN_END: begin
                if (model_idle_rate == 8'd0)
                    want = ({rep_slots, 8'h00, rep_mods} != rep_last_sent);
                else
                    want = 1'b1;
            end
            default: begin
                // Timer tick: count down the idle period, resend when it runs out.
                if (model_idle_rate != 8'd0) begin
                    if (rep_idle_count > IDLE_LIMIT) begin
                        rep_idle_count = rep_idle_count - IDLE_STEP;
                    end else begin
                        want           = 1'b1;
                        rep_idle_count = model_idle_rate;
                    end
                end
            end
        endcase
        res.send = want && it.host_ready;
        if (res.send)
            rep_last_sent = {rep_slots, 8'h00, rep_mods};
        res.modifier_bits = rep_mods;
        res.slots         = rep_slots;
        res.rolled_over   = rep_rolled;
        return res;
    endfunction

    function automatic t_item make_item(t_kind kind, logic [7:0] code, logic rdy);
        t_item it;
        it.kind       = kind;
        it.key_code   = code;
        it.host_ready = rdy;
        return it;
    endfunction

    task automatic push_item(t_kind kind, logic [7:0] code, logic rdy);
        scan_items.push_back(make_item(kind, code, rdy));
        items_queued++;
    endtask

    // A third of the picks hit the modifier window of the current base.
    function automatic logic [7:0] pick_key();
        if ($urandom_range(0, 2) == 0)
            return model_mod_base + 8'd1 + 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(string what, logic [7:0] exp_v, logic [7:0] got_v);
        errors++;
        if (errors <= 10)
            $display("mismatch on report %0d, %s: expected 0x%02h, got 0x%02h",
                     reports_seen, what, exp_v, got_v);
    endtask

    // Write one register through the configuration channel and mirror it.
    task automatic write_register(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.addr  <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        if (idx == REG_IDLE_RATE)
            model_idle_rate = val;
        else if (idx == REG_MODIFIER_BASE)
            model_mod_base = val;
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [7:0] idle, logic [7:0] base);
        write_register(REG_IDLE_RATE, idle);
        write_register(REG_MODIFIER_BASE, base);
        settings_run++;
    endtask

    // Hold until every queued item is taken and every report has come back,
    // then let the pipe settle for its latency.
    task automatic wait_drained();
        while (items_taken != items_queued || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly well-formed scans with random content, plus replays of the
    // previous scan, bursts of ticks and free noise.
    task automatic queue_random(int count);
        int   added;
        int   pick;
        int   n;
        t_item it;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 20 && last_scan.size() > 0) begin
                // Replay the same scan: unchanged reports go out only on idle.
                foreach (last_scan[i]) begin
                    it = last_scan[i];
                    push_item(it.kind, it.key_code, it.host_ready);
                end
                added += last_scan.size();
            end else if (pick < 70) begin
                last_scan.delete();
                last_scan.push_back(make_item(KIND_SCAN_START, 8'($urandom_range(0, 255)),
                                              1'($urandom_range(0, 1))));
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 6);
                repeat (n)
                    last_scan.push_back(make_item(KIND_KEY, pick_key(),
                                                  1'($urandom_range(0, 1))));
                last_scan.push_back(make_item(KIND_SCAN_END, 8'($urandom_range(0, 255)),
                                              $urandom_range(0, 6) != 0));
                foreach (last_scan[i]) begin
                    it = last_scan[i];
                    push_item(it.kind, it.key_code, it.host_ready);
                end
                added += last_scan.size();
            end else if (pick < 85) begin
                n = $urandom_range(1, 12);
                repeat (n)
                    push_item(KIND_TICK, 8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0);
                added += n;
            end else begin
                push_item(t_kind'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    // Driver: present the next item once the current one has transferred,
    // with random gaps between items.
    always @(posedge i_clk) begin : item_driver
        t_item nxt;
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else begin
            // Predict at the transfer edge, from the item that was on the bus.
            if (item_bus.valid && item_bus.ready) begin
                expected_reports.push_back(update_report(on_bus));
                items_taken++;
            end
            if (!item_bus.valid || item_bus.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    item_bus.valid <= 1'b0;
                end else if (scan_items.size() > 0) begin
                    nxt                 = scan_items.pop_front();
                    on_bus              = nxt;
                    item_bus.valid      <= 1'b1;
                    item_bus.kind       <= nxt.kind;
                    item_bus.key_code   <= nxt.key_code;
                    item_bus.host_ready <= nxt.host_ready;
                    if (!no_idle && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 15);
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the result side in random bursts and check every report
    // that transfers against the oldest prediction.
    always @(posedge i_clk) begin : report_monitor
        t_result                   exp_r;
        logic [MAX_SLOTS-1:0][7:0] got_slots;
        if (!i_rst_n) begin
            report_bus.ready <= 1'b0;
        end else begin
            if (report_bus.valid && report_bus.ready) begin
                reports_seen++;
                if (report_bus.send)
                    sends_seen++;
                if (expected_reports.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("report %0d arrived with no item to account for it",
                                 reports_seen);
                end else begin
                    exp_r     = expected_reports.pop_front();
                    got_slots = {report_bus.slot_f, report_bus.slot_e, report_bus.slot_d,
                                 report_bus.slot_c, report_bus.slot_b, report_bus.slot_a};
                    if (report_bus.send !== exp_r.send)
                        report_mismatch("send", 8'(exp_r.send), 8'(report_bus.send));
                    if (report_bus.modifier_bits !== exp_r.modifier_bits)
                        report_mismatch("modifier_bits", exp_r.modifier_bits,
                                        report_bus.modifier_bits);
                    for (int i = 0; i < MAX_SLOTS; i++)
                        if (got_slots[i] !== exp_r.slots[i])
                            report_mismatch($sformatf("slot %0d", i), exp_r.slots[i],
                                            got_slots[i]);
                    if (report_bus.rolled_over !== exp_r.rolled_over)
                        report_mismatch("rolled_over", 8'(exp_r.rolled_over),
                                        8'(report_bus.rolled_over));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                report_bus.ready <= 1'b0;
            end else begin
                report_bus.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0)
                    sink_gap = $urandom_range(1, 15);
            end
        end
    end

    // Main sequence: reset, directed checks, then random phases per setting.
    initial begin
        // Drive every input to a known value before the first edge.
        i_rst_n             = 1'b0;
        item_bus.valid      = 1'b0;
        item_bus.kind       = KIND_SCAN_START;
        item_bus.key_code   = 8'd0;
        item_bus.host_ready = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.addr        = REG_IDLE_RATE;
        cfg_bus.data        = 8'd0;
        report_bus.ready    = 1'b0;

        model_idle_rate = IDLE_RATE_RESET;
        model_mod_base  = MODIFIER_BASE_RESET;
        rep_mods        = '0;
        rep_slots       = '0;
        rep_next_slot   = '0;
        rep_last_sent   = '0;
        rep_idle_count  = '0;
        rep_rolled      = 1'b0;
        items_queued    = 0;
        items_taken     = 0;
        reports_seen    = 0;
        sends_seen      = 0;
        errors          = 0;
        settings_run    = 0;
        src_gap         = 0;
        sink_gap        = 0;
        no_idle         = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset-value setting written explicitly.
        apply_setting(8'd0, 8'd223);
        push_item(KIND_TICK, 8'hFF, 1'b1);        // tick with no idle period: no send
        push_item(KIND_SCAN_END, 8'h00, 1'b1);    // empty report equals last sent
        push_item(KIND_SCAN_START, 8'h00, 1'b1);
        for (int k = 224; k <= 231; k++)
            push_item(KIND_KEY, 8'(k), 1'b1);     // all eight modifier bits
        push_item(KIND_KEY, 8'd223, 1'b1);        // base itself is an ordinary key
        push_item(KIND_KEY, 8'd232, 1'b1);        // just past the modifier window
        push_item(KIND_KEY, 8'd0, 1'b0);
        push_item(KIND_KEY, 8'd255, 1'b1);
        push_item(KIND_KEY, 8'd4, 1'b1);
        push_item(KIND_KEY, 8'd5, 1'b1);          // sixth slot filled
        push_item(KIND_KEY, 8'd7, 1'b1);          // overflow: rollover codes
        push_item(KIND_SCAN_END, 8'h00, 1'b0);    // host busy: send dropped
        push_item(KIND_SCAN_END, 8'h00, 1'b1);    // changed, sent
        push_item(KIND_SCAN_END, 8'h00, 1'b1);    // unchanged, held back
        push_item(KIND_KEY, 8'd9, 1'b1);          // key with no scan start
        push_item(KIND_SCAN_START, 8'hFF, 1'b0);
        push_item(KIND_SCAN_END, 8'hFF, 1'b1);    // cleared report differs: sent
        wait_drained();

        // Random phases across settings, the extremes among them.
        apply_setting(8'd255, 8'd246);
        queue_random(250);
        wait_drained();

        apply_setting(8'd1, 8'd0);
        queue_random(250);
        wait_drained();

        apply_setting(8'd5, 8'd100);
        queue_random(250);
        wait_drained();

        // Last phase runs with both sides always ready.
        apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 246)));
        no_idle = 1'b1;
        queue_random(250);
        wait_drained();
        repeat (6) @(posedge i_clk);

        $display("covered %0d items over %0d register settings, %0d reports checked",
                 items_taken, settings_run, reports_seen);
        $display("%0d reports went to the host, %0d mismatches found", sends_seen, errors);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
